// ===== rtl/motion_trail_compositor_defines.svh =====
// ----------------------------------------------------------------------------
// Motion trail compositor: assertion macros
// Shared property forms for the checker of the compositor. Each macro expects
// signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MOTION_TRAIL_COMPOSITOR_DEFINES_SVH
`define MOTION_TRAIL_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed number of cycles between cause and effect.
`define MTC_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== rtl/mtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion trail compositor package
// Sizes, codes, pixel types, the tint palette and small arithmetic helpers.
// ----------------------------------------------------------------------------
package mtc_pkg;

  // Largest canvas the store can hold.
  localparam int unsigned MAX_CANVAS_WIDTH  = 2048;
  localparam int unsigned MAX_CANVAS_HEIGHT = 1024;

  // Fixed field widths.
  localparam int unsigned OP_BITS        = 2;
  localparam int unsigned ORD_BITS       = 10;
  localparam int unsigned SRC_BITS       = 13;
  localparam int unsigned COORD_BITS     = 12;
  localparam int unsigned CHAN_BITS      = 8;
  localparam int unsigned CFG_W_BITS     = 12;
  localparam int unsigned CFG_H_BITS     = 11;
  localparam int unsigned THRESH_BITS    = 10;
  localparam int unsigned CFG_DATA_BITS  = 12;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Register reset values.
  localparam int unsigned RST_OUT_WIDTH  = 1280;
  localparam int unsigned RST_OUT_HEIGHT = 720;
  localparam int unsigned RST_THRESHOLD  = 48;

  // Canvas size after clamping, and the canvas index ranges.
  localparam int unsigned CANVAS_W_BITS = $clog2(MAX_CANVAS_WIDTH + 1);
  localparam int unsigned CANVAS_H_BITS = $clog2(MAX_CANVAS_HEIGHT + 1);
  localparam int unsigned X_INDEX_BITS  = $clog2(MAX_CANVAS_WIDTH);
  localparam int unsigned Y_INDEX_BITS  = $clog2(MAX_CANVAS_HEIGHT);

  // Placed coordinate: centering offset plus source position.
  localparam int unsigned CX_SPAN_BITS = $clog2(MAX_CANVAS_WIDTH / 2 + (1 << COORD_BITS));
  localparam int unsigned CY_SPAN_BITS = $clog2(MAX_CANVAS_HEIGHT / 2 + (1 << COORD_BITS));
  localparam int unsigned CX_BITS = (CX_SPAN_BITS > CANVAS_W_BITS) ? CX_SPAN_BITS : CANVAS_W_BITS;
  localparam int unsigned CY_BITS = (CY_SPAN_BITS > CANVAS_H_BITS) ? CY_SPAN_BITS : CANVAS_H_BITS;

  // Store geometry.
  localparam int unsigned STORE_DEPTH     = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
  localparam int unsigned STORE_ADDR_BITS = $clog2(STORE_DEPTH);

  // Sum of three channel differences.
  localparam int unsigned SUM_BITS = CHAN_BITS + 2;

  // Cycles from an accepted beat to its result strobe.
  localparam int unsigned RESULT_LATENCY = 4;

  // Palette and the reciprocal constants for the divisions by 3 and by 6.
  localparam int unsigned PALETTE_SIZE = 6;
  localparam int unsigned PAL_IDX_BITS = 3;
  localparam int unsigned PAL_BIAS     = PALETTE_SIZE - 1;
  localparam int unsigned DIV3_RECIP   = 683;
  localparam int unsigned DIV3_SHIFT   = 11;
  localparam int unsigned DIV6_RECIP   = 683;
  localparam int unsigned DIV6_SHIFT   = 12;
  localparam int unsigned BLEND_BITS   = CHAN_BITS + 2;
  localparam int unsigned DIV3_PROD    = BLEND_BITS + DIV3_SHIFT;
  localparam int unsigned DIV6_PROD    = ORD_BITS + 1 + DIV6_SHIFT;

  typedef enum logic [OP_BITS-1:0] {
    OP_BASE  = 2'd0,
    OP_LATER = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_OUT_WIDTH  = 2'd0,
    CFG_OUT_HEIGHT = 2'd1,
    CFG_THRESHOLD  = 2'd2,
    CFG_TINT_EN    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] r;
    logic [CHAN_BITS-1:0] g;
    logic [CHAN_BITS-1:0] b;
  } rgb_t;

  // One store entry: the base pixel and the composite pixel side by side.
  typedef struct packed {
    rgb_t base;
    rgb_t comp;
  } entry_t;

  localparam int unsigned ENTRY_BITS = $bits(entry_t);

  localparam rgb_t TINT_PALETTE [PALETTE_SIZE] = '{
    '{r: 8'd255, g: 8'd92,  b: 8'd92},
    '{r: 8'd255, g: 8'd174, b: 8'd66},
    '{r: 8'd255, g: 8'd232, b: 8'd92},
    '{r: 8'd88,  g: 8'd216, b: 8'd255},
    '{r: 8'd180, g: 8'd132, b: 8'd255},
    '{r: 8'd255, g: 8'd120, b: 8'd216}
  };

  // Divide a value below 1024 by three through a reciprocal multiply.
  function automatic logic [CHAN_BITS-1:0] div3(input logic [BLEND_BITS-1:0] x);
    logic [DIV3_PROD-1:0] prod;
    prod = DIV3_PROD'(x) * DIV3_PROD'(DIV3_RECIP);
    return CHAN_BITS'(prod >> DIV3_SHIFT);
  endfunction

  // Palette entry for a frame ordinal: (ordinal + 5) mod 6.
  function automatic logic [PAL_IDX_BITS-1:0] pal_index(input logic [ORD_BITS-1:0] ord);
    logic [ORD_BITS:0]    x;
    logic [DIV6_PROD-1:0] prod;
    logic [ORD_BITS:0]    quo;
    logic [ORD_BITS:0]    rem;
    x    = (ORD_BITS + 1)'(ord) + (ORD_BITS + 1)'(PAL_BIAS);
    prod = DIV6_PROD'(x) * DIV6_PROD'(DIV6_RECIP);
    quo  = (ORD_BITS + 1)'(prod >> DIV6_SHIFT);
    rem  = x - (ORD_BITS + 1)'(quo * (ORD_BITS + 1)'(PALETTE_SIZE));
    return rem[PAL_IDX_BITS-1:0];
  endfunction

endpackage

// ===== rtl/mtc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered and a read
// at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module mtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read share one process for read-old behavior.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/motion_trail_compositor.sv =====
// ----------------------------------------------------------------------------
// Motion trail compositor
// Places source pixels on a centered canvas, keeps base and composite pixels
// in one store, merges moving pixels into the composite and serves reads.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Transfer
//  -------  --------------------------------------  -----------------------------
//  config   cfg_we, cfg_index, cfg_wdata            write when cfg_we is high
//  input    start, busy, in_*                       beat when start && !busy
//  result   out_valid, out_*                        one-cycle strobe, no stall
//
//  One beat is accepted every cycle while busy is low; a read result is formed
//  by the stages in order: place, multiply for the row base, add and issue the
//  read, then the read-modify-write, whose result is registered.
//  Back-to-back beats to the same entry are forwarded from the last write.
//  busy is high during reset and is registered low once reset is released.
//  The receiver cannot stall; results are never held.
//
module motion_trail_compositor (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mtc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mtc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic [mtc_pkg::OP_BITS-1:0]         in_operation,
  input  logic [mtc_pkg::ORD_BITS-1:0]        in_frame_ordinal,
  input  logic [mtc_pkg::SRC_BITS-1:0]        in_src_width_px,
  input  logic [mtc_pkg::SRC_BITS-1:0]        in_src_height_px,
  input  logic [mtc_pkg::COORD_BITS-1:0]      in_col,
  input  logic [mtc_pkg::COORD_BITS-1:0]      in_row,
  input  logic [mtc_pkg::CHAN_BITS-1:0]       in_red_in,
  input  logic [mtc_pkg::CHAN_BITS-1:0]       in_green_in,
  input  logic [mtc_pkg::CHAN_BITS-1:0]       in_blue_in,
  output logic                                out_valid,
  output logic [mtc_pkg::CHAN_BITS-1:0]       out_red_out,
  output logic [mtc_pkg::CHAN_BITS-1:0]       out_green_out,
  output logic [mtc_pkg::CHAN_BITS-1:0]       out_blue_out,
  output logic                                out_in_canvas
);

  localparam int unsigned CW  = mtc_pkg::CANVAS_W_BITS;
  localparam int unsigned CH  = mtc_pkg::CANVAS_H_BITS;
  localparam int unsigned CX  = mtc_pkg::CX_BITS;
  localparam int unsigned CY  = mtc_pkg::CY_BITS;
  localparam int unsigned XI  = mtc_pkg::X_INDEX_BITS;
  localparam int unsigned YI  = mtc_pkg::Y_INDEX_BITS;
  localparam int unsigned AW  = mtc_pkg::STORE_ADDR_BITS;
  localparam int unsigned SB  = mtc_pkg::SRC_BITS;
  localparam int unsigned XE  = (CW > SB) ? CW : SB;
  localparam int unsigned YE  = (CH > SB) ? CH : SB;
  localparam int unsigned CHB = mtc_pkg::CHAN_BITS;
  localparam int unsigned BB  = mtc_pkg::BLEND_BITS;
  localparam int unsigned SUM = mtc_pkg::SUM_BITS;

  typedef struct packed {
    mtc_pkg::op_t                       op;
    logic [CX-1:0]                      cx;
    logic [CY-1:0]                      cy;
    mtc_pkg::rgb_t                      pix;
    logic [mtc_pkg::PAL_IDX_BITS-1:0]   pal;
  } s1_t;

  typedef struct packed {
    mtc_pkg::op_t  op;
    logic          on_canvas;
    logic [AW-1:0] row_base;
    logic [XI-1:0] cx_idx;
    mtc_pkg::rgb_t pix;
    mtc_pkg::rgb_t blend;
  } s2_t;

  typedef struct packed {
    mtc_pkg::op_t  op;
    logic          on_canvas;
    logic [AW-1:0] addr;
    mtc_pkg::rgb_t pix;
    mtc_pkg::rgb_t blend;
  } s3_t;

  // Configuration registers.
  logic [mtc_pkg::CFG_W_BITS-1:0]  cfg_width_r,  cfg_width_nxt;
  logic [mtc_pkg::CFG_H_BITS-1:0]  cfg_height_r, cfg_height_nxt;
  logic [mtc_pkg::THRESH_BITS-1:0] cfg_thresh_r, cfg_thresh_nxt;
  logic                            cfg_tint_r,   cfg_tint_nxt;

  // Pipeline.
  logic busy_r, busy_nxt;
  logic s1_vld_r, s1_vld_nxt, s2_vld_r, s2_vld_nxt, s3_vld_r, s3_vld_nxt;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;

  // Last store write, for forwarding to the next beat.
  logic                          fwd_vld_r, fwd_vld_nxt;
  logic [AW-1:0]                 fwd_addr_r, fwd_addr_nxt;
  mtc_pkg::entry_t               fwd_data_r, fwd_data_nxt;

  // Result register.
  logic          out_vld_r, out_vld_nxt;
  mtc_pkg::rgb_t out_rgb_r, out_rgb_nxt;
  logic          out_inc_r, out_inc_nxt;

  // Shared combinational values.
  logic                  accept;
  logic [CW-1:0]         canvas_w;
  logic [CH-1:0]         canvas_h;
  logic [31:0]           w_ext, h_ext;
  logic [XE-1:0]         cw_e, sw_e, offx;
  logic [YE-1:0]         ch_e, sh_e, offy;
  mtc_pkg::op_t          in_op;
  mtc_pkg::rgb_t         pal_rgb;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  mtc_pkg::entry_t       ram_rdata, cur;
  logic                  mem_we;
  mtc_pkg::entry_t       mem_wdata;
  logic [SUM-1:0]        diff_sum;
  logic                  moving;
  mtc_pkg::rgb_t         merged;

  function automatic logic [CHB-1:0] absdiff(input logic [CHB-1:0] a, input logic [CHB-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CHB-1:0] maxc(input logic [CHB-1:0] a, input logic [CHB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Configuration writes.
  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    cfg_thresh_nxt = cfg_thresh_r;
    cfg_tint_nxt   = cfg_tint_r;
    if (cfg_we) begin
      case (mtc_pkg::cfg_index_t'(cfg_index))
        mtc_pkg::CFG_OUT_WIDTH:  cfg_width_nxt  = cfg_wdata[mtc_pkg::CFG_W_BITS-1:0];
        mtc_pkg::CFG_OUT_HEIGHT: cfg_height_nxt = cfg_wdata[mtc_pkg::CFG_H_BITS-1:0];
        mtc_pkg::CFG_THRESHOLD:  cfg_thresh_nxt = cfg_wdata[mtc_pkg::THRESH_BITS-1:0];
        mtc_pkg::CFG_TINT_EN:    cfg_tint_nxt   = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Canvas size with zero raised to one and large values saturated.
  always_comb begin
    w_ext = 32'(cfg_width_r);
    h_ext = 32'(cfg_height_r);
    if (w_ext == 32'd0) begin
      canvas_w = CW'(1);
    end else if (w_ext > 32'(mtc_pkg::MAX_CANVAS_WIDTH)) begin
      canvas_w = CW'(mtc_pkg::MAX_CANVAS_WIDTH);
    end else begin
      canvas_w = CW'(w_ext);
    end
    if (h_ext == 32'd0) begin
      canvas_h = CH'(1);
    end else if (h_ext > 32'(mtc_pkg::MAX_CANVAS_HEIGHT)) begin
      canvas_h = CH'(mtc_pkg::MAX_CANVAS_HEIGHT);
    end else begin
      canvas_h = CH'(h_ext);
    end
  end

  // Stage 0: accept a beat, center base and later pixels on the canvas, pick the palette entry.
  always_comb begin
    accept   = start && !busy_r;
    busy_nxt = 1'b0;
    in_op    = mtc_pkg::op_t'(in_operation);
    cw_e     = XE'(canvas_w);
    sw_e     = XE'(in_src_width_px);
    ch_e     = YE'(canvas_h);
    sh_e     = YE'(in_src_height_px);
    offx     = (cw_e > sw_e) ? ((cw_e - sw_e) >> 1) : '0;
    offy     = (ch_e > sh_e) ? ((ch_e - sh_e) >> 1) : '0;

    s1_vld_nxt = accept;
    s1_nxt.op  = in_op;
    if (in_op == mtc_pkg::OP_BASE || in_op == mtc_pkg::OP_LATER) begin
      s1_nxt.cx = CX'(offx) + CX'(in_col);
      s1_nxt.cy = CY'(offy) + CY'(in_row);
    end else begin
      s1_nxt.cx = CX'(in_col);
      s1_nxt.cy = CY'(in_row);
    end
    s1_nxt.pix.r = in_red_in;
    s1_nxt.pix.g = in_green_in;
    s1_nxt.pix.b = in_blue_in;
    s1_nxt.pal   = mtc_pkg::pal_index(in_frame_ordinal);
  end

  // Stage 1: bounds check, row base multiply and the tint blend when tint is enabled.
  always_comb begin
    pal_rgb          = mtc_pkg::TINT_PALETTE[s1_r.pal];
    s2_vld_nxt       = s1_vld_r;
    s2_nxt.op        = s1_r.op;
    s2_nxt.on_canvas = (s1_r.cx < CX'(canvas_w)) && (s1_r.cy < CY'(canvas_h));
    s2_nxt.row_base  = AW'(s1_r.cy[YI-1:0]) * AW'(canvas_w);
    s2_nxt.cx_idx    = s1_r.cx[XI-1:0];
    s2_nxt.pix       = s1_r.pix;
    if (cfg_tint_r) begin
      s2_nxt.blend.r = mtc_pkg::div3({1'b0, s1_r.pix.r, 1'b0} + BB'(pal_rgb.r));
      s2_nxt.blend.g = mtc_pkg::div3({1'b0, s1_r.pix.g, 1'b0} + BB'(pal_rgb.g));
      s2_nxt.blend.b = mtc_pkg::div3({1'b0, s1_r.pix.b, 1'b0} + BB'(pal_rgb.b));
    end else begin
      s2_nxt.blend = s1_r.pix;
    end
  end

  // Stage 2: form the entry address and issue the store read.
  always_comb begin
    rd_addr          = s2_r.row_base + AW'(s2_r.cx_idx);
    rd_en            = s2_vld_r && s2_r.on_canvas;
    s3_vld_nxt       = s2_vld_r;
    s3_nxt.op        = s2_r.op;
    s3_nxt.on_canvas = s2_r.on_canvas;
    s3_nxt.addr      = rd_addr;
    s3_nxt.pix       = s2_r.pix;
    s3_nxt.blend     = s2_r.blend;
  end

  mtc_ram #(
    .WIDTH (mtc_pkg::ENTRY_BITS),
    .DEPTH (mtc_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s3_r.addr),
    .wdata (mem_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Stage 3: read-modify-write of the entry or the read result, with forwarding of the last write.
  always_comb begin
    cur = (fwd_vld_r && (fwd_addr_r == s3_r.addr)) ? fwd_data_r : ram_rdata;

    diff_sum = SUM'(absdiff(s3_r.pix.r, cur.base.r)) +
               SUM'(absdiff(s3_r.pix.g, cur.base.g)) +
               SUM'(absdiff(s3_r.pix.b, cur.base.b));
    moving   = diff_sum >= SUM'(cfg_thresh_r);
    merged.r = maxc(s3_r.blend.r, cur.comp.r);
    merged.g = maxc(s3_r.blend.g, cur.comp.g);
    merged.b = maxc(s3_r.blend.b, cur.comp.b);

    mem_we    = 1'b0;
    mem_wdata = cur;
    case (s3_r.op)
      mtc_pkg::OP_BASE: begin
        mem_we    = s3_vld_r && s3_r.on_canvas;
        mem_wdata = '{base: s3_r.pix, comp: s3_r.pix};
      end
      mtc_pkg::OP_LATER: begin
        mem_we    = s3_vld_r && s3_r.on_canvas && moving;
        mem_wdata = '{base: cur.base, comp: merged};
      end
      mtc_pkg::OP_CLEAR: begin
        mem_we    = s3_vld_r && s3_r.on_canvas;
        mem_wdata = '0;
      end
      default: ;
    endcase

    fwd_vld_nxt  = mem_we;
    fwd_addr_nxt = s3_r.addr;
    fwd_data_nxt = mem_wdata;

    out_vld_nxt = s3_vld_r && (s3_r.op == mtc_pkg::OP_READ);
    out_inc_nxt = s3_r.on_canvas;
    out_rgb_nxt = s3_r.on_canvas ? cur.comp : '0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= mtc_pkg::CFG_W_BITS'(mtc_pkg::RST_OUT_WIDTH);
      cfg_height_r <= mtc_pkg::CFG_H_BITS'(mtc_pkg::RST_OUT_HEIGHT);
      cfg_thresh_r <= mtc_pkg::THRESH_BITS'(mtc_pkg::RST_THRESHOLD);
      cfg_tint_r   <= 1'b1;
      busy_r       <= 1'b1;
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      fwd_vld_r    <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      cfg_thresh_r <= cfg_thresh_nxt;
      cfg_tint_r   <= cfg_tint_nxt;
      busy_r       <= busy_nxt;
      s1_vld_r     <= s1_vld_nxt;
      s2_vld_r     <= s2_vld_nxt;
      s3_vld_r     <= s3_vld_nxt;
      fwd_vld_r    <= fwd_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    s3_r       <= s3_nxt;
    fwd_addr_r <= fwd_addr_nxt;
    fwd_data_r <= fwd_data_nxt;
    out_rgb_r  <= out_rgb_nxt;
    out_inc_r  <= out_inc_nxt;
  end

  assign busy          = busy_r;
  assign out_valid     = out_vld_r;
  assign out_red_out   = out_rgb_r.r;
  assign out_green_out = out_rgb_r.g;
  assign out_blue_out  = out_rgb_r.b;
  assign out_in_canvas = out_inc_r;

endmodule

// ===== rtl/mtc_checker.sv =====
// ----------------------------------------------------------------------------
// Motion trail compositor checker
// Port-level assertions on result timing and read results, bound to the top.
// ----------------------------------------------------------------------------
`include "motion_trail_compositor_defines.svh"

module mtc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic [mtc_pkg::OP_BITS-1:0]         in_operation,
  input logic                                out_valid,
  input logic [mtc_pkg::CHAN_BITS-1:0]       out_red_out,
  input logic [mtc_pkg::CHAN_BITS-1:0]       out_green_out,
  input logic [mtc_pkg::CHAN_BITS-1:0]       out_blue_out,
  input logic                                out_in_canvas
);

  localparam int unsigned LAT = mtc_pkg::RESULT_LATENCY;

  logic beat;
  logic read_beat;

  assign beat      = start && !busy;
  assign read_beat = beat && (in_operation == mtc_pkg::OP_READ);

  // Every read beat yields exactly one result after the fixed latency.
  `MTC_ASSERT_DELAY(a_read_gives_result, read_beat, LAT, out_valid, "read beat without result")

  // Other beats never produce a result.
  `MTC_ASSERT_DELAY(a_write_no_result, beat && !read_beat, LAT, !out_valid, "result from non-read beat")

  // A result strobe always traces back to an accepted beat.
  `MTC_ASSERT_IMPL(a_result_has_beat, out_valid, $past(beat, LAT), "result without a beat")

  // Reads outside the canvas return a black pixel.
  `MTC_ASSERT_IMPL(a_outside_black, out_valid && !out_in_canvas,
                   out_red_out == '0 && out_green_out == '0 && out_blue_out == '0,
                   "outside read returned color")

endmodule

bind motion_trail_compositor mtc_checker u_mtc_checker (.*);
